[hdl/score_table_top_k_sum_unit_macros.svh]
// assertion macros shared by the score table design
`ifndef SCORE_TABLE_TOP_K_SUM_UNIT_MACROS_SVH
`define SCORE_TABLE_TOP_K_SUM_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ST_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define ST_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/st_pkg.sv]
// types and codes for the score table top-k sum block
package st_pkg;

  // op codes carried on the input tuser
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // sequencer states, one-hot
  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_UPD   = 8'b00000010,
    S_SCAN  = 8'b00000100,
    S_DRAIN = 8'b00001000,
    S_PEND  = 8'b00010000,
    S_MUL   = 8'b00100000,
    S_FIN   = 8'b01000000,
    S_INIT  = 8'b10000000
  } state_t;

  // control from the sequencer to the compare and accumulate unit
  typedef struct packed {
    logic clr;
    logic en;
  } st_ctl_t;

endpackage

[hdl/st_ram.sv]
// generic single-write, single-read ram with registered read data
module st_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/st_acc.sv]
// shared compare and accumulate unit used by every table pass
module st_acc #(
  parameter int SCORE_BITS = 24,
  parameter int CW         = 9
) (
  input  logic                     clk,
  input  logic                     rst,
  input  st_pkg::st_ctl_t          ctl,
  input  logic [SCORE_BITS-1:0]    datum,
  input  logic [SCORE_BITS-1:0]    ref_val,
  output logic [CW-1:0]            cnt,
  output logic [SCORE_BITS+CW-1:0] acc
);

  logic hit;

  // one comparator: entry strictly above the reference
  assign hit = datum > ref_val;

  // count and sum the entries that pass the compare
  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      cnt <= '0;
      acc <= '0;
    end else if (ctl.en && hit) begin
      cnt <= cnt + CW'(1);
      acc <= acc + (SCORE_BITS+CW)'(datum);
    end
  end

endmodule

[hdl/score_table_top_k_sum_unit.sv]
// top level: score table with add, clear and top-k sum query
//
// Input channel s_*: op on s_tuser, player_id/amount/count on s_tdata.
// Output channel m_*: one top_sum item per query; add and clear give none.
// An add reads the entry, then writes the saturated sum; a clear writes from idle.
// A query finds the k-th largest score T by a radix search, one bit per
// pass over the table from the top bit down, each pass counting entries
// at or above the candidate; a last pass counts and sums entries above T,
// and the result is that sum plus (k - count) * T, saturated to 32 bits.
// Each pass reads every entry through the single ram read port; a query
// with count zero skips the passes.
// One item is worked on at a time; s_tready is high only when idle.
// A finished result sits in an output register; if it has not been taken
// when the next result is ready, the block waits until m_tready.
// Reset empties the output register and starts a clearing pass that writes
// zero to every table entry, with s_tready low.
module score_table_top_k_sum_unit #(
  parameter int PLAYERS    = 256,
  parameter int SCORE_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // player_id[7:0], amount[23:8], count[32:24], zero pad
  input  logic [1:0]  s_tuser,  // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // top_sum[31:0]
);

  `include "score_table_top_k_sum_unit_macros.svh"

  localparam int AW = $clog2(PLAYERS);
  localparam int CW = $clog2(PLAYERS + 1);
  localparam int BW = (SCORE_BITS > 1) ? $clog2(SCORE_BITS) : 1;
  localparam int SW = ((SCORE_BITS > 16) ? SCORE_BITS : 16) + 1;
  localparam int PW = CW + SCORE_BITS;
  localparam int TW = (PW + 1 > 33) ? PW + 1 : 33;

  st_pkg::state_t          state;
  logic [AW-1:0]           idx;
  logic [BW-1:0]           bitn;
  logic                    phase_sum;
  logic [CW-1:0]           k;
  logic [SCORE_BITS-1:0]   thr;
  logic [AW-1:0]           upd_addr;
  logic [15:0]             upd_amt;
  logic                    d1_vld;
  logic [PW-1:0]           prod;

  logic                    accept;
  logic [1:0]              op;
  logic [7:0]              player_id;
  logic [15:0]             amount;
  logic [8:0]              count;
  logic                    in_range;
  logic [AW-1:0]           id_addr;
  logic                    we;
  logic [AW-1:0]           waddr;
  logic [SCORE_BITS-1:0]   wdata;
  logic [AW-1:0]           raddr;
  logic [SCORE_BITS-1:0]   rdata;
  logic [SCORE_BITS-1:0]   datum;
  logic [SW-1:0]           add_sum;
  logic [SCORE_BITS-1:0]   sat_score;
  logic [SCORE_BITS-1:0]   cand;
  logic [SCORE_BITS-1:0]   ref_val;
  logic [CW-1:0]           cnt;
  logic [SCORE_BITS+CW-1:0] acc;
  logic [TW-1:0]           total;
  logic                    out_free;
  st_pkg::st_ctl_t         ctl;

  // input field unpacking
  assign op        = s_tuser;
  assign player_id = s_tdata[7:0];
  assign amount    = s_tdata[23:8];
  assign count     = s_tdata[32:24];
  assign in_range  = 32'(player_id) < PLAYERS;
  assign id_addr   = AW'(player_id);

  assign s_tready = (state == st_pkg::S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // table ram: clears write from idle, adds write in the update state,
  // the reset pass zeroes every entry
  assign we    = (accept && op == st_pkg::OP_CLEAR && in_range) ||
                 (state == st_pkg::S_UPD) || (state == st_pkg::S_INIT);
  assign waddr = (state == st_pkg::S_IDLE) ? id_addr :
                 (state == st_pkg::S_INIT) ? idx : upd_addr;
  assign wdata = (state == st_pkg::S_UPD) ? sat_score : '0;
  assign raddr = (state == st_pkg::S_IDLE) ? id_addr : idx;

  st_ram #(
    .WIDTH (SCORE_BITS),
    .DEPTH (PLAYERS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign datum = rdata;

  // saturating add for the update
  assign add_sum   = SW'(datum) + SW'(upd_amt);
  assign sat_score = (add_sum > SW'({SCORE_BITS{1'b1}})) ? {SCORE_BITS{1'b1}}
                                                       : SCORE_BITS'(add_sum);

  // radix search candidate and compare reference
  assign cand    = thr | (SCORE_BITS'(1) << bitn);
  assign ref_val = phase_sum ? thr : (cand - SCORE_BITS'(1));

  assign ctl.clr = (accept && op == st_pkg::OP_QUERY) || (state == st_pkg::S_PEND && !phase_sum);
  assign ctl.en  = d1_vld;

  st_acc #(
    .SCORE_BITS (SCORE_BITS),
    .CW         (CW)
  ) u_acc (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .datum   (datum),
    .ref_val (ref_val),
    .cnt     (cnt),
    .acc     (acc)
  );

  assign total    = TW'(acc) + TW'(prod);
  assign out_free = !m_tvalid || m_tready;

  // read pipeline flag
  always_ff @(posedge clk) begin
    if (rst) begin
      d1_vld <= 1'b0;
    end else begin
      d1_vld <= (state == st_pkg::S_SCAN);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= st_pkg::S_INIT;
      idx       <= '0;
      bitn      <= '0;
      phase_sum <= 1'b0;
      k         <= '0;
      thr       <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      // output register: load from the finishing state, empty on handshake
      if (state == st_pkg::S_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        st_pkg::S_INIT: begin
          if (idx == AW'(PLAYERS - 1)) begin
            idx   <= '0;
            state <= st_pkg::S_IDLE;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        st_pkg::S_IDLE: begin
          if (accept && op == st_pkg::OP_ADD && in_range) begin
            upd_addr <= id_addr;
            upd_amt  <= amount;
            state    <= st_pkg::S_UPD;
          end else if (accept && op == st_pkg::OP_QUERY) begin
            k         <= (32'(count) > PLAYERS) ? CW'(PLAYERS) : CW'(count);
            thr       <= '0;
            bitn      <= BW'(SCORE_BITS - 1);
            phase_sum <= 1'b0;
            idx       <= '0;
            state     <= (count == '0) ? st_pkg::S_MUL : st_pkg::S_SCAN;
          end
        end
        st_pkg::S_UPD: begin
          state <= st_pkg::S_IDLE;
        end
        st_pkg::S_SCAN: begin
          if (idx == AW'(PLAYERS - 1)) begin
            idx   <= '0;
            state <= st_pkg::S_DRAIN;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        st_pkg::S_DRAIN: begin
          state <= st_pkg::S_PEND;
        end
        st_pkg::S_PEND: begin
          if (phase_sum) begin
            state <= st_pkg::S_MUL;
          end else begin
            if (cnt >= k) begin
              thr <= cand;
            end
            if (bitn == '0) begin
              phase_sum <= 1'b1;
            end else begin
              bitn <= bitn - BW'(1);
            end
            state <= st_pkg::S_SCAN;
          end
        end
        st_pkg::S_MUL: begin
          prod  <= PW'(k - cnt) * PW'(thr);
          state <= st_pkg::S_FIN;
        end
        st_pkg::S_FIN: begin
          if (out_free) begin
            m_tdata <= (total > TW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(total);
            state   <= st_pkg::S_IDLE;
          end
        end
        default: begin
          state <= st_pkg::S_IDLE;
        end
      endcase
    end
  end

  // entries above the k-th largest never exceed k
  `ST_ASSERT_IMP(a_cnt_le_k, state == st_pkg::S_MUL, cnt <= k, "count above threshold exceeds k")
  // an update always follows an accepted add
  `ST_ASSERT_IMP(a_upd_src, state == st_pkg::S_UPD,
                 $past(accept) && $past(op) == st_pkg::OP_ADD, "update without add item")
  // a result is only loaded from the finishing state
  `ST_ASSERT_NXT(a_out_load, !m_tvalid && state != st_pkg::S_FIN, !m_tvalid,
                 "result appeared outside the finishing state")

endmodule
